[hw/rtl/led_light_program_sequencer_core_macros.svh]
// assertion macros for the light program sequencer
`ifndef LED_LIGHT_PROGRAM_SEQUENCER_CORE_MACROS_SVH
`define LED_LIGHT_PROGRAM_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define LPSQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define LPSQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lpsq_pkg.sv]
// shared types and constants of the light program sequencer
`default_nettype none
package lpsq_pkg;

    localparam int NUM_CHANNELS_DEF        = 24;
    localparam int PROGRAM_LENGTH_DEF      = 20;
    localparam int PROGRAMMED_CHANNELS_DEF = 23;

    localparam int STEP_W    = 5;
    localparam int LEVEL_W   = 8;
    localparam int ACC_W     = 16;
    localparam int DIVIDEND_W = 17;
    localparam int DIVISOR_W  = 8;

    localparam logic [STEP_W-1:0] PARKED_STEP = 5'd22;

    localparam logic [7:0] CMD_END      = 8'd0;
    localparam logic [7:0] CMD_DIM_MAX  = 8'd200;
    localparam logic [7:0] CMD_JUMP_LO  = 8'd201;
    localparam logic [7:0] CMD_JUMP_HI  = 8'd220;
    localparam logic [7:0] CMD_SET      = 8'd221;
    localparam logic [7:0] CMD_DELAY    = 8'd222;
    localparam logic [7:0] CMD_RANDOM   = 8'd223;
    localparam logic [7:0] CMD_NOP      = 8'd224;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

[hw/rtl/lpsq_if.sv]
// request and level-report channel interfaces
`default_nettype none
interface lpsq_in_if import lpsq_pkg::*; ();
    logic        valid;
    logic        ready;
    t_opcode     opcode;
    logic [4:0]  channel;
    logic        all_channels;
    logic [4:0]  step_index;
    logic [7:0]  program_byte;
    logic [7:0]  random_value;

    modport source (output valid, opcode, channel, all_channels, step_index,
                    program_byte, random_value, input ready);
    modport sink (input valid, opcode, channel, all_channels, step_index,
                  program_byte, random_value, output ready);
endinterface

interface lpsq_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] out_channel;
    logic [7:0] level;
    logic       last;

    modport source (output valid, out_channel, level, last, input ready);
    modport sink (input valid, out_channel, level, last, output ready);
endinterface
`default_nettype wire

[hw/rtl/lpsq_div.sv]
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module lpsq_div import lpsq_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_num;
    logic [DIVISOR_W-1:0]  r_den;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W:0]    n_shift;
    logic                  n_ge;

    assign n_shift = {r_rem, r_num[DIVIDEND_W-1]};
    assign n_ge    = n_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
                r_num  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_ge ? DIVISOR_W'(n_shift - {1'b0, r_den})
                              : DIVISOR_W'(n_shift);
                r_num <= {r_num[DIVIDEND_W-2:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num;
endmodule
`default_nettype wire

[hw/rtl/led_light_program_sequencer_core.sv]
// top level of the light program sequencer
// A tick request steps every channel in ascending order and reports one level per channel,
// last set on the final channel; write, start and stop requests produce no report. After
// reset all PROGRAMMED_CHANNELS*PROGRAM_LENGTH entries of the program memory are cleared
// before the first request is taken. After a tick is accepted in S_IDLE, each channel
// goes through S_CHK, S_LOAD and S_WAIT if it is counting down or stopped, through S_CHK,
// S_CMD, S_LOAD and S_WAIT for a one-byte command, and also through S_ARG after S_CMD for
// a command with an argument, while a channel that begins a dim also waits in S_DIV for the
// shared bit-serial divider. Each report waits in an output register for as long as it is
// not taken. Start and stop sweep each channel in S_CHK; a write is done in S_IDLE.
`default_nettype none
`include "led_light_program_sequencer_core_macros.svh"
module led_light_program_sequencer_core import lpsq_pkg::*; #(
    parameter int NUM_CHANNELS        = NUM_CHANNELS_DEF,
    parameter int PROGRAM_LENGTH      = PROGRAM_LENGTH_DEF,
    parameter int PROGRAMMED_CHANNELS = PROGRAMMED_CHANNELS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lpsq_in_if.sink    i_req,
    lpsq_out_if.source o_rsp
);
    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int STORE = PROGRAMMED_CHANNELS * PROGRAM_LENGTH;
    localparam int AW    = $clog2(STORE);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CHK, S_CMD, S_ARG, S_DIV, S_LOAD, S_WAIT
    } t_state;

    t_state r_state;
    logic [CH_W-1:0]      r_ch;
    logic [AW-1:0]        r_clr;
    t_opcode              r_op;
    logic [4:0]           r_sel;
    logic                 r_all;
    logic [STEP_W-1:0]    r_idx;
    logic [7:0]           r_rnd;
    logic [7:0]           r_cmd;
    logic                 r_upd;
    logic                 r_neg;
    logic                 r_ok;
    logic                 r_ctrl;

    logic [ACC_W-1:0]   r_acc   [NUM_CHANNELS];
    logic [ACC_W-1:0]   r_slope [NUM_CHANNELS];
    logic [7:0]         r_ticks [NUM_CHANNELS];
    logic [STEP_W-1:0]  r_sp    [NUM_CHANNELS];
    logic [LEVEL_W-1:0] r_shown [NUM_CHANNELS];

    logic [7:0] r_mem [STORE];
    logic [7:0] r_mem_q;

    logic               r_o_valid;
    logic [LEVEL_W-1:0] r_o_level;

    logic [ACC_W-1:0]   cur_acc;
    logic [ACC_W-1:0]   cur_slope;
    logic [7:0]         cur_ticks;
    logic [STEP_W-1:0]  cur_sp;
    logic [STEP_W-1:0]  sp_inc;
    logic [STEP_W-1:0]  rd_pos;
    logic [AW-1:0]      rd_addr;
    logic               rd_ok;
    logic [7:0]         byte_q;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic [17:0]        n_diff;
    logic [ACC_W-1:0]   n_qs;
    logic [ACC_W-1:0]   n_slope;
    logic [LEVEL_W-1:0] n_shown;
    logic               ch_last;
    logic               ch_hit;
    logic               req_acc;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign cur_acc   = r_acc[r_ch];
    assign cur_slope = r_slope[r_ch];
    assign cur_ticks = r_ticks[r_ch];
    assign cur_sp    = r_sp[r_ch];
    assign sp_inc    = cur_sp + 1'b1;
    assign rd_pos    = (r_state == S_CMD) ? sp_inc : cur_sp;
    assign rd_ok     = (7'(r_ch) < 7'(PROGRAMMED_CHANNELS)) && (6'(rd_pos) < 6'(PROGRAM_LENGTH));
    assign rd_addr   = AW'(r_ch * PROGRAM_LENGTH + rd_pos);
    assign byte_q    = r_ok ? r_mem_q : CMD_END;
    assign ch_last   = r_ch == CH_W'(NUM_CHANNELS - 1);
    assign ch_hit    = r_all || (7'(r_ch) == 7'(r_sel));
    assign req_acc   = i_req.valid && i_req.ready;

    assign wr_en   = (r_state == S_CLEAR) || (req_acc && i_req.opcode == OP_WRITE
                     && 7'(i_req.channel) < 7'(PROGRAMMED_CHANNELS)
                     && 6'(i_req.step_index) < 6'(PROGRAM_LENGTH));
    assign wr_addr = (r_state == S_CLEAR) ? r_clr
                   : AW'(i_req.channel * PROGRAM_LENGTH + i_req.step_index);
    assign wr_data = (r_state == S_CLEAR) ? 8'd0 : i_req.program_byte;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_mem_q <= r_mem[rd_addr];
    end

    assign n_diff = {2'b00, byte_q, 8'h00} - {2'b00, cur_acc};
    assign div_req.start    = (r_state == S_ARG) && (r_cmd != CMD_END) && (r_cmd <= CMD_DIM_MAX);
    assign div_req.dividend = n_diff[17] ? DIVIDEND_W'(-n_diff) : DIVIDEND_W'(n_diff);
    assign div_req.divisor  = r_cmd;

    assign n_qs    = r_neg ? ACC_W'(-div_rsp.quotient) : ACC_W'(div_rsp.quotient);
    assign n_slope = (n_qs != '0 && !n_qs[ACC_W-1]) ? n_qs + 1'b1 : n_qs;
    assign n_shown = r_upd ? cur_acc[ACC_W-1 -: LEVEL_W] : r_shown[r_ch];

    lpsq_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_ch      <= '0;
            r_o_valid <= 1'b0;
            r_ctrl    <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_acc[i]   <= '0;
                r_slope[i] <= '0;
                r_ticks[i] <= '0;
                r_sp[i]    <= PARKED_STEP;
                r_shown[i] <= '0;
            end
        end else begin
            r_ok <= rd_ok;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(STORE - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (req_acc) begin
                        r_op  <= i_req.opcode;
                        r_sel <= i_req.channel;
                        r_all <= i_req.all_channels;
                        r_idx <= i_req.step_index;
                        r_rnd <= i_req.random_value;
                        r_ch  <= '0;
                        if (i_req.opcode == OP_TICK) begin
                            r_ctrl  <= 1'b0;
                            r_state <= S_CHK;
                        end else if (i_req.opcode != OP_WRITE) begin
                            r_ctrl  <= 1'b1;
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    if (r_ctrl) begin
                        if (ch_hit) begin
                            r_ticks[r_ch] <= '0;
                            if (r_op == OP_START) begin
                                r_sp[r_ch] <= r_idx;
                            end else begin
                                r_sp[r_ch]    <= PARKED_STEP;
                                r_acc[r_ch]   <= '0;
                                r_shown[r_ch] <= '0;
                            end
                        end
                        r_ch <= r_ch + 1'b1;
                        if (ch_last) r_state <= S_IDLE;
                    end else if (cur_ticks != '0) begin
                        r_acc[r_ch]   <= cur_acc + cur_slope;
                        r_ticks[r_ch] <= cur_ticks - 1'b1;
                        r_upd         <= 1'b1;
                        r_state       <= S_LOAD;
                    end else if (6'(cur_sp) >= 6'(PROGRAM_LENGTH)) begin
                        r_upd   <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_upd   <= 1'b1;
                        r_state <= S_CMD;
                    end
                end
                S_CMD: begin
                    r_cmd      <= byte_q;
                    r_sp[r_ch] <= sp_inc;
                    r_state    <= S_LOAD;
                    if (byte_q == CMD_END) begin
                        r_sp[r_ch] <= PARKED_STEP;
                    end else if (byte_q <= CMD_DIM_MAX) begin
                        r_state <= S_ARG;
                    end else if (byte_q <= CMD_JUMP_HI) begin
                        r_sp[r_ch] <= STEP_W'(byte_q - CMD_JUMP_LO);
                    end else if (byte_q == CMD_SET || byte_q == CMD_DELAY
                                 || byte_q == CMD_RANDOM) begin
                        r_state <= S_ARG;
                    end else if (byte_q != CMD_NOP) begin
                        r_sp[r_ch] <= STEP_W'(PROGRAM_LENGTH);
                    end
                end
                S_ARG: begin
                    r_sp[r_ch] <= sp_inc;
                    r_state    <= S_LOAD;
                    if (r_cmd == CMD_SET) begin
                        r_acc[r_ch] <= {byte_q, 8'h00};
                    end else if (r_cmd == CMD_DELAY) begin
                        r_slope[r_ch] <= '0;
                        r_ticks[r_ch] <= byte_q;
                    end else if (r_cmd == CMD_RANDOM) begin
                        r_slope[r_ch] <= '0;
                        r_ticks[r_ch] <= r_rnd;
                    end else begin
                        r_neg   <= n_diff[17];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_slope[r_ch] <= n_slope;
                        r_acc[r_ch]   <= cur_acc + n_slope;
                        r_ticks[r_ch] <= r_cmd - 1'b1;
                        r_state       <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_shown[r_ch] <= n_shown;
                    r_o_level     <= n_shown;
                    r_o_valid     <= 1'b1;
                    r_state       <= S_WAIT;
                end
                S_WAIT: begin
                    if (o_rsp.ready) begin
                        r_o_valid <= 1'b0;
                        if (ch_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_CHK;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready       = r_state == S_IDLE;
    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.level       = r_o_level;
    assign o_rsp.out_channel = 5'(r_ch);
    assign o_rsp.last        = ch_last;

    `LPSQ_ASSERT_IMP(a_no_report_when_idle, o_rsp.valid, !i_req.ready, "report while idle")
    `LPSQ_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, r_state == S_DIV, "stray divider done")
    `LPSQ_ASSERT_NXT(a_idle_after_last, o_rsp.valid && o_rsp.ready && o_rsp.last,
        i_req.ready, "not idle after last report")
endmodule
`default_nettype wire
